// File: rtl/core/sppsq_pkg.sv
// Package for the stepper phase pulse sequencer core.
// Holds register indexes, configuration and result types and the pin pattern tables.
// No dependencies.
package sppsq_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned StepW  = 31;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned OutDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PHASE_MODE       = 3'd0,
    CFG_DIRECTION        = 3'd1,
    CFG_STEP_COUNT       = 3'd2,
    CFG_PULSE_INTERVAL   = 3'd3,
    CFG_FIRST_PULSE_TIME = 3'd4,
    CFG_END_TIME         = 3'd5
  } cfg_idx_e;

  // Phase index bounds for the ten-phase sequence
  localparam logic [PhaseW-1:0] PhaseTenLast = 4'd9;

  typedef struct packed {
    logic             phase_mode;
    logic             direction;
    logic [TimeW-1:0] pulse_interval;
    logic [TimeW-1:0] first_pulse_time;
    logic [TimeW-1:0] end_time;
  } cfg_t;

  // New segment load: step_count write
  typedef struct packed {
    logic             load;
    logic [StepW-1:0] count;
  } seg_load_t;

  typedef struct packed {
    logic              stepped;
    logic [PhaseW-1:0] phase;
    logic              dir_pin;
    logic              step_pin;
    logic              ms1_pin;
    logic              ms2_pin;
    logic              ms3_pin;
    logic              done_res;
  } result_t;

  // Ten-phase pattern, bits: dir, step, ms1, ms2, ms3 (4 down to 0)
  function automatic logic [4:0] ten_pattern(input logic [PhaseW-1:0] idx);
    logic [4:0] p;
    case (idx)
      4'd0:    p = 5'h0D;
      4'd1:    p = 5'h09;
      4'd2:    p = 5'h0B;
      4'd3:    p = 5'h0A;
      4'd4:    p = 5'h1A;
      4'd5:    p = 5'h12;
      4'd6:    p = 5'h16;
      4'd7:    p = 5'h14;
      4'd8:    p = 5'h15;
      default: p = 5'h05; // nine and any out-of-range index
    endcase
    return p;
  endfunction

  // Four-phase pattern, bits: dir, step
  function automatic logic [1:0] four_pattern(input logic [1:0] idx);
    logic [1:0] p;
    case (idx)
      2'd0:    p = 2'h2;
      2'd1:    p = 2'h3;
      2'd2:    p = 2'h1;
      default: p = 2'h0;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/core/sppsq_cfg_regs.sv
// Configuration register file of the stepper phase pulse sequencer.
// Depends on sppsq_pkg.
module sppsq_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [sppsq_pkg::CfgIdxW-1:0] wr_idx_i,
  input  logic [sppsq_pkg::TimeW-1:0]   wr_data_i,
  output sppsq_pkg::cfg_t               cfg_o,
  output sppsq_pkg::seg_load_t          seg_load_o
);
  import sppsq_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register decode
  always_comb begin
    cfg_d = cfg_q;
    seg_load_o.load  = 1'b0;
    seg_load_o.count = wr_data_i[StepW-1:0];
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        CFG_PHASE_MODE:       cfg_d.phase_mode = wr_data_i[0];
        CFG_DIRECTION:        cfg_d.direction = wr_data_i[0];
        CFG_STEP_COUNT:       seg_load_o.load = 1'b1;
        CFG_PULSE_INTERVAL:   cfg_d.pulse_interval = wr_data_i;
        CFG_FIRST_PULSE_TIME: cfg_d.first_pulse_time = wr_data_i;
        CFG_END_TIME:         cfg_d.end_time = wr_data_i;
        default:              cfg_d = cfg_q; // unused index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_mode       <= 1'b0;
      cfg_q.direction        <= 1'b0;
      cfg_q.pulse_interval   <= TimeW'(1);
      cfg_q.first_pulse_time <= '0;
      cfg_q.end_time         <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/sppsq_step_unit.sv
// Step state and next-state logic: pulse due check, phase advance, pin decode.
// Depends on sppsq_pkg.
module sppsq_step_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sppsq_pkg::cfg_t             cfg_i,
  input  sppsq_pkg::seg_load_t        seg_load_i,
  input  logic                        fire_i,
  input  logic [sppsq_pkg::TimeW-1:0] now_us_i,
  output sppsq_pkg::result_t          res_o
);
  import sppsq_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [StepW-1:0]  steps_left_q, steps_left_d;
  logic [TimeW-1:0]  offset_q, offset_d;

  logic [TimeW-1:0]  next_time;
  logic [TimeW-1:0]  interval;
  logic              due;
  logic [PhaseW-1:0] phase_adv;
  logic [4:0]        ten_p;
  logic [1:0]        four_p;

  // Pulse due check
  assign next_time = cfg_i.first_pulse_time + offset_q;
  assign interval  = (cfg_i.pulse_interval == '0) ? TimeW'(1) : cfg_i.pulse_interval;
  assign due       = (steps_left_q != '0) && (now_us_i >= next_time);

  // Phase advance for either mode
  always_comb begin
    if (cfg_i.phase_mode) begin
      if (cfg_i.direction) begin
        phase_adv = (phase_q == '0 || phase_q > PhaseTenLast) ? PhaseTenLast
                                                              : phase_q - PhaseW'(1);
      end else begin
        phase_adv = (phase_q >= PhaseTenLast) ? '0 : phase_q + PhaseW'(1);
      end
    end else begin
      phase_adv = {2'b00, phase_q[1:0] + 2'd1};
    end
  end

  // State update; segment load wins (the user must write it only while idle; the block does not enforce this)
  always_comb begin
    phase_d      = phase_q;
    steps_left_d = steps_left_q;
    offset_d     = offset_q;
    if (seg_load_i.load) begin
      steps_left_d = seg_load_i.count;
      offset_d     = '0;
    end else if (fire_i && due) begin
      phase_d      = phase_adv;
      steps_left_d = steps_left_q - StepW'(1);
      offset_d     = offset_q + interval;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= '0;
      steps_left_q <= '0;
      offset_q     <= '0;
    end else begin
      phase_q      <= phase_d;
      steps_left_q <= steps_left_d;
      offset_q     <= offset_d;
    end
  end

  // Pin decode from the phase after this tick
  assign ten_p  = ten_pattern(fire_i && due ? phase_adv : phase_q);
  assign four_p = four_pattern(fire_i && due ? phase_adv[1:0] : phase_q[1:0]);

  always_comb begin
    res_o.stepped  = due;
    res_o.phase    = due ? phase_adv : phase_q;
    res_o.done_res = (cfg_i.end_time <= now_us_i);
    if (cfg_i.phase_mode) begin
      res_o.dir_pin  = ten_p[4];
      res_o.step_pin = ten_p[3];
      res_o.ms1_pin  = ten_p[2];
      res_o.ms2_pin  = ten_p[1];
      res_o.ms3_pin  = ten_p[0];
    end else begin
      res_o.dir_pin  = four_p[1];
      res_o.step_pin = four_p[0];
      res_o.ms1_pin  = 1'b0;
      res_o.ms2_pin  = 1'b0;
      res_o.ms3_pin  = 1'b0;
    end
  end

  // Phase never leaves the ten-phase range
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhaseTenLast)
    else $error("phase index out of range");

  // An issued pulse counts exactly one step off
  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && due && !seg_load_i.load |=> steps_left_q == $past(steps_left_q) - StepW'(1))
    else $error("step count not decremented");

  // Without a pulse or a load the segment state holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_i && due) && !seg_load_i.load |=> $stable(steps_left_q) && $stable(offset_q)
      && $stable(phase_q))
    else $error("segment state changed without a pulse");

endmodule

// File: rtl/core/stepper_phase_pulse_sequencer_core.sv
// Top level of the stepper phase pulse sequencer: input register, step unit, result register.
// Depends on sppsq_pkg, sppsq_cfg_regs and sppsq_step_unit.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   now_us
//  m_axis    out  m_axis_tvalid / m_axis_tready   stepped, phase, pins, done_res
//  cfg       in   cfg_valid_i / cfg_ready_o       cfg_addr_i index, cfg_data_i value
//
// One tick in and one result out per cycle unless results stall. The rate is set by the
// segment state update (compare, add, table decode). Reset clears the configuration to its
// defaults and the segment state to zero. A stalled result register holds the input
// register; the input takes a new beat whenever the input register moves on. Configuration
// is always ready; the user must write it only while idle, which the block does not enforce.
module stepper_phase_pulse_sequencer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sppsq_pkg::TimeW-1:0]      s_axis_tdata,  // [31:0] now_us
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] stepped, [4:1] phase, [5] dir_pin, [6] step_pin, [7] ms1_pin, [8] ms2_pin,
  // [9] ms3_pin, [10] done_res, [15:11] zero
  output logic [sppsq_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sppsq_pkg::CfgIdxW-1:0]    cfg_addr_i,
  input  logic [sppsq_pkg::TimeW-1:0]      cfg_data_i
);
  import sppsq_pkg::*;

  cfg_t      cfg;
  seg_load_t seg_load;
  result_t   res;

  logic             in_valid_q, in_valid_d;
  logic [TimeW-1:0] in_now_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_res_q;
  logic             advance;
  logic             in_beat;

  assign cfg_ready_o = 1'b1;

  sppsq_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_idx_i   (cfg_addr_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg),
    .seg_load_o (seg_load)
  );

  sppsq_step_unit u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .seg_load_i (seg_load),
    .fire_i     (advance),
    .now_us_i   (in_now_q),
    .res_o      (res)
  );

  // Pipeline flow control
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_beat) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      in_now_q <= s_axis_tdata;
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_res_q.done_res, out_res_q.ms3_pin, out_res_q.ms2_pin,
                          out_res_q.ms1_pin, out_res_q.step_pin, out_res_q.dir_pin,
                          out_res_q.phase, out_res_q.stepped};

  // An empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input blocked with empty result register");

  // A waiting tick holds while the result side stalls
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_now_q))
    else $error("waiting tick lost");

  // Every processed tick leaves a result beat
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed tick gave no result");

endmodule

// File: tb/stepper_phase_pulse_sequencer_core_tb.sv
// Self-checking testbench for stepper_phase_pulse_sequencer_core: random and directed time ticks
// and segment setups, with a per-tick tracker of phase, pins and done. Depends on sppsq_pkg.
module stepper_phase_pulse_sequencer_core_tb;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned SegTicks    = 62;
  localparam int unsigned SegCount    = 12;
  // Register indexes past the last one; writes there must be ignored
  localparam logic [sppsq_pkg::CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [sppsq_pkg::CfgIdxW-1:0] RegSpareB = 3'd7;

  // Tracks segment state and queues the expected result of every accepted tick
  class phase_tracker;
    bit        ten_mode;
    bit        dir_down;
    bit [30:0] steps_left;
    bit [31:0] interval_us;
    bit [31:0] first_us;
    bit [31:0] end_us;
    bit [31:0] pulse_off;
    bit [3:0]  phase_idx;
    sppsq_pkg::result_t pending[$];
    int unsigned errors;

    function new();
      ten_mode    = 1'b0;
      dir_down    = 1'b0;
      steps_left  = '0;
      interval_us = 32'd1;
      first_us    = '0;
      end_us      = '0;
      pulse_off   = '0;
      phase_idx   = '0;
      errors      = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [31:0] val);
      case (idx)
        sppsq_pkg::CFG_PHASE_MODE:       ten_mode = val[0];
        sppsq_pkg::CFG_DIRECTION:        dir_down = val[0];
        sppsq_pkg::CFG_STEP_COUNT: begin
          // new segment: reload the step budget, restart from the first pulse time
          steps_left = val[30:0];
          pulse_off  = '0;
        end
        sppsq_pkg::CFG_PULSE_INTERVAL:   interval_us = val;
        sppsq_pkg::CFG_FIRST_PULSE_TIME: first_us = val;
        sppsq_pkg::CFG_END_TIME:         end_us = val;
        default: ;
      endcase
    endfunction

    // dir, step, ms1, ms2, ms3 from bit 4 down; nine and anything above share one entry
    function bit [4:0] ten_pins(bit [3:0] p);
      case (p)
        4'd0:    return 5'h0D;
        4'd1:    return 5'h09;
        4'd2:    return 5'h0B;
        4'd3:    return 5'h0A;
        4'd4:    return 5'h1A;
        4'd5:    return 5'h12;
        4'd6:    return 5'h16;
        4'd7:    return 5'h14;
        4'd8:    return 5'h15;
        default: return 5'h05;
      endcase
    endfunction

    // dir, step
    function bit [1:0] four_pins(bit [1:0] p);
      case (p)
        2'd0:    return 2'h2;
        2'd1:    return 2'h3;
        2'd2:    return 2'h1;
        default: return 2'h0;
      endcase
    endfunction

    function void note_tick(bit [31:0] now);
      bit [31:0] due_at;
      bit [31:0] step_us;
      sppsq_pkg::result_t r;
      due_at  = first_us + pulse_off;
      step_us = (interval_us == 32'd0) ? 32'd1 : interval_us;
      r = '0;
      if (steps_left != 31'd0 && now >= due_at) begin
        if (ten_mode) begin
          if (dir_down) begin
            phase_idx = (phase_idx == 4'd0 || phase_idx > sppsq_pkg::PhaseTenLast) ?
                        sppsq_pkg::PhaseTenLast : phase_idx - 4'd1;
          end else begin
            phase_idx = (phase_idx >= sppsq_pkg::PhaseTenLast) ? 4'd0 : phase_idx + 4'd1;
          end
        end else begin
          phase_idx = {2'b00, phase_idx[1:0] + 2'd1};
        end
        pulse_off  = pulse_off + step_us;
        steps_left = steps_left - 31'd1;
        r.stepped  = 1'b1;
      end
      // pins follow the phase on every tick, stepped or not
      if (ten_mode) begin
        {r.dir_pin, r.step_pin, r.ms1_pin, r.ms2_pin, r.ms3_pin} = ten_pins(phase_idx);
      end else begin
        {r.dir_pin, r.step_pin} = four_pins(phase_idx[1:0]);
      end
      r.phase    = phase_idx;
      r.done_res = (end_us <= now);
      pending.push_back(r);
    endfunction

    function void field_cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_beat(logic [15:0] beat);
      sppsq_pkg::result_t exp_r;
      if (pending.size() == 0) begin
        $error("result beat 0x%h with no tick waiting", beat);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      field_cmp("stepped",  32'(exp_r.stepped),  32'(beat[0]));
      field_cmp("phase",    32'(exp_r.phase),    32'(beat[4:1]));
      field_cmp("dir_pin",  32'(exp_r.dir_pin),  32'(beat[5]));
      field_cmp("step_pin", 32'(exp_r.step_pin), 32'(beat[6]));
      field_cmp("ms1_pin",  32'(exp_r.ms1_pin),  32'(beat[7]));
      field_cmp("ms2_pin",  32'(exp_r.ms2_pin),  32'(beat[8]));
      field_cmp("ms3_pin",  32'(exp_r.ms3_pin),  32'(beat[9]));
      field_cmp("done_res", 32'(exp_r.done_res), 32'(beat[10]));
      field_cmp("padding",  32'd0,               32'(beat[15:11]));
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [sppsq_pkg::TimeW-1:0]        s_axis_tdata = '0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [sppsq_pkg::OutDataW-1:0]     m_axis_tdata;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [sppsq_pkg::CfgIdxW-1:0]      cfg_addr_i = '0;
  logic [sppsq_pkg::TimeW-1:0]        cfg_data_i = '0;

  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  cycle_cnt      = 0;
  phase_tracker trk;

  stepper_phase_pulse_sequencer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Beat monitor: values sampled here are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) trk.note_tick(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) trk.check_beat(m_axis_tdata);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One tick beat; may leave a random idle gap after it
  task automatic send_tick(input bit [31:0] now);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now;
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Stop sending and let every outstanding result drain; the extra edge lets the
  // monitor note the last accepted tick first
  task automatic idle_wait();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (trk.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register write; close drops valid afterwards
  task automatic cfg_write(input bit [2:0] idx, input bit [31:0] val, input bit close);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    trk.write_reg(idx, val);
    if (close) cfg_valid_i <= 1'b0;
  endtask

  task automatic load_segment(input bit [31:0] mode_w, input bit [31:0] dir_w,
                              input bit [31:0] steps_w, input bit [31:0] ivl,
                              input bit [31:0] first, input bit [31:0] last_us,
                              input bit reload, input bit junk);
    cfg_write(sppsq_pkg::CFG_PHASE_MODE, mode_w, 1'b0);
    cfg_write(sppsq_pkg::CFG_DIRECTION, dir_w, 1'b0);
    cfg_write(sppsq_pkg::CFG_PULSE_INTERVAL, ivl, 1'b0);
    cfg_write(sppsq_pkg::CFG_FIRST_PULSE_TIME, first, 1'b0);
    if (junk) begin
      cfg_write(RegSpareA, $urandom, 1'b0);
      cfg_write(RegSpareB, $urandom, 1'b0);
    end
    cfg_write(sppsq_pkg::CFG_END_TIME, last_us, !reload);
    if (reload) cfg_write(sppsq_pkg::CFG_STEP_COUNT, steps_w, 1'b1);
  endtask

  // Hand-picked corners
  task automatic directed_run();
    bit [31:0] t;
    // reset defaults: no steps, end time zero
    send_tick(32'd0);
    send_tick(32'hFFFF_FFFF);
    idle_wait();
    // only the step budget set; default interval of one
    cfg_write(sppsq_pkg::CFG_STEP_COUNT, 32'd3, 1'b1);
    send_tick(32'd0);
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'd5);
    send_tick(32'd9);
    idle_wait();
    // ten-phase upward with a zero interval, wraps past nine
    load_segment(32'd1, 32'd0, 32'd12, 32'd0, 32'd100, 32'd105, 1'b1, 1'b0);
    for (t = 32'd99; t <= 32'd108; t++) send_tick(t);
    idle_wait();
    // ten-phase downward, largest budget and interval, time wrap, wraps below zero
    load_segment(32'd1, 32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                 1'b1, 1'b0);
    send_tick(32'hFFFF_FFFE);
    repeat (5) send_tick(32'hFFFF_FFFF);
    idle_wait();
    // back to four-phase with a leftover ten-phase index; spare indexes written
    load_segment(32'd0, 32'd1, 32'd2, 32'd1, 32'd10, 32'd0, 1'b1, 1'b1);
    send_tick(32'd5);
    send_tick(32'd10);
    send_tick(32'd11);
  endtask

  // Random segment: mostly ticks walking toward and past pulse times, some noise
  task automatic run_segment();
    int unsigned r;
    bit [31:0]   mode_w;
    bit [31:0]   dir_w;
    bit [31:0]   steps_w;
    bit [31:0]   ivl;
    bit [31:0]   first;
    bit [31:0]   last_us;
    bit [31:0]   step_us;
    bit [31:0]   t;
    bit          reload;
    bit          junk;
    mode_w = $urandom_range(1);
    dir_w  = $urandom_range(1);
    if ($urandom_range(3) == 0) begin
      mode_w |= $urandom & 32'hFFFF_FFFE;
      dir_w  |= $urandom & 32'hFFFF_FFFE;
    end
    case ($urandom_range(9))
      0:       steps_w = 32'd0;
      1:       steps_w = 32'h7FFF_FFFF;
      2:       steps_w = $urandom;
      default: steps_w = $urandom_range(1, 40);
    endcase
    case ($urandom_range(7))
      0:       ivl = 32'd0;
      1:       ivl = 32'hFFFF_FFFF;
      2:       ivl = $urandom;
      default: ivl = $urandom_range(1, 6);
    endcase
    case ($urandom_range(5))
      0:       first = 32'd0;
      1:       first = 32'hFFFF_FFFF - $urandom_range(20);
      2:       first = $urandom;
      default: first = $urandom_range(0, 1000);
    endcase
    case ($urandom_range(5))
      0:       last_us = 32'd0;
      1:       last_us = 32'hFFFF_FFFF;
      2:       last_us = $urandom;
      default: last_us = first + $urandom_range(0, 150);
    endcase
    reload = ($urandom_range(5) != 0);
    junk   = ($urandom_range(4) == 0);
    load_segment(mode_w, dir_w, steps_w, ivl, first, last_us, reload, junk);
    step_us = (ivl == 32'd0) ? 32'd1 : ivl;
    t = first - $urandom_range(0, 4);
    repeat (SegTicks) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_tick($urandom);
      end else begin
        if (r >= 14) t = t + ((r & 1) ? step_us : $urandom_range(0, 3));
        send_tick(t);
      end
    end
  endtask

  // Main sequence
  initial begin
    trk = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_run();
    for (int seg = 0; seg < SegCount; seg++) begin
      idle_wait();
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      run_segment();
    end
    idle_wait();
    if (trk.errors == 0 && trk.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/sppsq_pkg.sv
rtl/core/sppsq_cfg_regs.sv
rtl/core/sppsq_step_unit.sv
rtl/core/stepper_phase_pulse_sequencer_core.sv
tb/stepper_phase_pulse_sequencer_core_tb.sv
